FILE: hw/rtl/tic_pkg.sv
package tic_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned ClassW = 7;
  localparam int unsigned DispW  = 3;
  localparam int unsigned CountW = 4;
  localparam int unsigned RegW   = 4;

  typedef struct packed {
    logic [HalfW-1:0] first_half;
    logic [HalfW-1:0] second_half;
    logic [AddrW-1:0] pc_addr;
  } in_item_t;

  typedef struct packed {
    logic              is_wide;
    logic [ClassW-1:0] op_class;
    logic              target_valid;
    logic [AddrW-1:0]  dest_addr;
    logic [DispW-1:0]  disp_kind;
    logic              has_reg_list;
    logic [CountW-1:0] reg_count;
    logic              list_has_pc_or_lr;
    logic [RegW-1:0]   branch_reg;
  } result_t;

  // displacement kinds
  localparam logic [DispW-1:0] DK_NONE     = 3'd0;
  localparam logic [DispW-1:0] DK_DISP8    = 3'd1;
  localparam logic [DispW-1:0] DK_DISP11   = 3'd2;
  localparam logic [DispW-1:0] DK_DISP24   = 3'd3;
  localparam logic [DispW-1:0] DK_INDIRECT = 3'd4;

  // class codes
  localparam logic [ClassW-1:0] CLS_UNK     = 7'd0;
  localparam logic [ClassW-1:0] CLS_LSL_I   = 7'd1;
  localparam logic [ClassW-1:0] CLS_LSR_I   = 7'd2;
  localparam logic [ClassW-1:0] CLS_ASR_I   = 7'd3;
  localparam logic [ClassW-1:0] CLS_ADD_R   = 7'd4;
  localparam logic [ClassW-1:0] CLS_MOV_I   = 7'd8;
  localparam logic [ClassW-1:0] CLS_CMP_I   = 7'd9;
  localparam logic [ClassW-1:0] CLS_ADD_I8  = 7'd10;
  localparam logic [ClassW-1:0] CLS_SUB_I8  = 7'd11;
  localparam logic [ClassW-1:0] CLS_AND     = 7'd12;
  localparam logic [ClassW-1:0] CLS_CMP_R   = 7'd22;
  localparam logic [ClassW-1:0] CLS_MOV_R   = 7'd28;
  localparam logic [ClassW-1:0] CLS_BX      = 7'd29;
  localparam logic [ClassW-1:0] CLS_BLX     = 7'd30;
  localparam logic [ClassW-1:0] CLS_LDR_LIT = 7'd31;
  localparam logic [ClassW-1:0] CLS_STR_R   = 7'd32;
  localparam logic [ClassW-1:0] CLS_LDR_R   = 7'd36;
  localparam logic [ClassW-1:0] CLS_STR_I   = 7'd40;
  localparam logic [ClassW-1:0] CLS_LDR_I   = 7'd41;
  localparam logic [ClassW-1:0] CLS_STRB_I  = 7'd42;
  localparam logic [ClassW-1:0] CLS_LDRB_I  = 7'd43;
  localparam logic [ClassW-1:0] CLS_STRH_I  = 7'd44;
  localparam logic [ClassW-1:0] CLS_LDRH_I  = 7'd45;
  localparam logic [ClassW-1:0] CLS_ADR     = 7'd46;
  localparam logic [ClassW-1:0] CLS_ADD_SP_I = 7'd47;
  localparam logic [ClassW-1:0] CLS_SUB_SP_I = 7'd48;
  localparam logic [ClassW-1:0] CLS_SXTH    = 7'd49;
  localparam logic [ClassW-1:0] CLS_PUSH    = 7'd53;
  localparam logic [ClassW-1:0] CLS_CPS     = 7'd54;
  localparam logic [ClassW-1:0] CLS_REV     = 7'd55;
  localparam logic [ClassW-1:0] CLS_REV16   = 7'd56;
  localparam logic [ClassW-1:0] CLS_REVSH   = 7'd57;
  localparam logic [ClassW-1:0] CLS_POP     = 7'd58;
  localparam logic [ClassW-1:0] CLS_BKPT    = 7'd59;
  localparam logic [ClassW-1:0] CLS_NOP     = 7'd60;
  localparam logic [ClassW-1:0] CLS_STM     = 7'd65;
  localparam logic [ClassW-1:0] CLS_LDM     = 7'd66;
  localparam logic [ClassW-1:0] CLS_B_COND  = 7'd67;
  localparam logic [ClassW-1:0] CLS_UDF     = 7'd68;
  localparam logic [ClassW-1:0] CLS_SVC     = 7'd69;
  localparam logic [ClassW-1:0] CLS_B       = 7'd70;
  localparam logic [ClassW-1:0] CLS_MSR     = 7'd71;
  localparam logic [ClassW-1:0] CLS_DSB     = 7'd72;
  localparam logic [ClassW-1:0] CLS_DMB     = 7'd73;
  localparam logic [ClassW-1:0] CLS_ISB     = 7'd74;
  localparam logic [ClassW-1:0] CLS_MRS     = 7'd75;
  localparam logic [ClassW-1:0] CLS_BL      = 7'd76;

endpackage

FILE: hw/rtl/thumb_instruction_classifier.sv
// Decodes one ARMv6-M Thumb instruction per clock. An instruction is taken
// when start_i is high (busy_o stays low, so every cycle can transfer), and
// its result appears on result_o with result_valid_o high for exactly one
// cycle, after passing through the input register and then the result
// register, with the decode and the 32-bit target add between them.
// Results come out in order and must be captured on that cycle; the
// block has no way to hold them.
module thumb_instruction_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tic_pkg::in_item_t in_item_i,
  output logic              result_valid_o,
  output tic_pkg::result_t  result_o
);
  import tic_pkg::*;

  logic     in_valid_d, in_valid_q;
  in_item_t in_d, in_q;
  logic     res_valid_d, res_valid_q;
  result_t  res_d, res_q;

  assign busy_o      = 1'b0;
  assign in_valid_d  = start_i & ~busy_o;
  assign in_d        = in_item_i;
  assign res_valid_d = in_valid_q;

  tic_decode u_decode (
    .item_i   (in_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_q <= in_d;
    end
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> result_valid_o)
    else $error("decoded item did not reach the result register");

  a_target_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.target_valid) |->
      (result_o.disp_kind == DK_DISP8 || result_o.disp_kind == DK_DISP11 ||
       result_o.disp_kind == DK_DISP24))
    else $error("target without direct displacement kind");

  a_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.target_valid) |-> (result_o.dest_addr == '0))
    else $error("target address set without a valid target");

  a_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.has_reg_list) |->
      (result_o.reg_count == '0 && !result_o.list_has_pc_or_lr))
    else $error("register list fields set for a non-list instruction");

endmodule

FILE: hw/rtl/tic_decode.sv
module tic_decode (
  input  tic_pkg::in_item_t item_i,
  output tic_pkg::result_t  result_o
);
  import tic_pkg::*;

  logic [HalfW-1:0]  h;
  logic [HalfW-1:0]  lo;
  logic              wide;
  logic [ClassW-1:0] nar_cls;
  logic [ClassW-1:0] wid_cls;
  logic [ClassW-1:0] cls;
  logic [AddrW-1:0]  disp;
  logic [AddrW-1:0]  sum;
  logic [CountW-1:0] ones;
  logic              push_pop;
  logic              is_list;

  assign h    = item_i.first_half;
  assign lo   = item_i.second_half;
  assign wide = (h[15:11] >= 5'h1d);

  always_comb begin
    nar_cls = CLS_UNK;
    unique case (h[15:11])
      5'd0:  nar_cls = CLS_LSL_I;
      5'd1:  nar_cls = CLS_LSR_I;
      5'd2:  nar_cls = CLS_ASR_I;
      5'd3:  nar_cls = CLS_ADD_R + {5'd0, h[10:9]};
      5'd4:  nar_cls = CLS_MOV_I;
      5'd5:  nar_cls = CLS_CMP_I;
      5'd6:  nar_cls = CLS_ADD_I8;
      5'd7:  nar_cls = CLS_SUB_I8;
      5'd8: begin
        if (!h[10]) begin
          nar_cls = CLS_AND + {3'd0, h[9:6]};
        end else begin
          unique case (h[9:8])
            2'd0: nar_cls = CLS_ADD_R;
            2'd1: nar_cls = (h[7:6] != 2'd0) ? CLS_CMP_R : CLS_UNK;
            2'd2: nar_cls = (h[7] && (h[2:0] == 3'b111)) ? CLS_BX : CLS_MOV_R;
            default: nar_cls = h[7] ? CLS_BLX : CLS_BX;
          endcase
        end
      end
      5'd9:  nar_cls = CLS_LDR_LIT;
      5'd10: nar_cls = CLS_STR_R + {5'd0, h[10:9]};
      5'd11: nar_cls = CLS_LDR_R + {5'd0, h[10:9]};
      5'd12: nar_cls = CLS_STR_I;
      5'd13: nar_cls = CLS_LDR_I;
      5'd14: nar_cls = CLS_STRB_I;
      5'd15: nar_cls = CLS_LDRB_I;
      5'd16: nar_cls = CLS_STRH_I;
      5'd17: nar_cls = CLS_LDRH_I;
      5'd18: nar_cls = CLS_STR_I;
      5'd19: nar_cls = CLS_LDR_I;
      5'd20: nar_cls = CLS_ADR;
      5'd21: nar_cls = CLS_ADD_SP_I;
      5'd22: begin
        if (!h[10]) begin
          priority if (h[9:7] == 3'b000) begin
            nar_cls = CLS_ADD_SP_I;
          end else if (h[9:7] == 3'b001) begin
            nar_cls = CLS_SUB_SP_I;
          end else if (h[9:8] == 2'b10) begin
            nar_cls = CLS_SXTH + {5'd0, h[7:6]};
          end else begin
            nar_cls = CLS_UNK;
          end
        end else if (!h[9]) begin
          nar_cls = CLS_PUSH;
        end else begin
          nar_cls = (h[8:5] == 4'b0011) ? CLS_CPS : CLS_UNK;
        end
      end
      5'd23: begin
        if (!h[10]) begin
          unique case (h[9:6])
            4'd8:    nar_cls = CLS_REV;
            4'd9:    nar_cls = CLS_REV16;
            4'd11:   nar_cls = CLS_REVSH;
            default: nar_cls = CLS_UNK;
          endcase
        end else if (!h[9]) begin
          nar_cls = CLS_POP;
        end else if (!h[8]) begin
          nar_cls = CLS_BKPT;
        end else begin
          nar_cls = (h[7:4] <= 4'd4) ? CLS_NOP + {3'd0, h[7:4]} : CLS_UNK;
        end
      end
      5'd24: nar_cls = CLS_STM;
      5'd25: nar_cls = CLS_LDM;
      5'd26, 5'd27: begin
        if (h[11:9] != 3'b111) begin
          nar_cls = CLS_B_COND;
        end else begin
          nar_cls = h[8] ? CLS_SVC : CLS_UDF;
        end
      end
      5'd28: nar_cls = CLS_B;
      default: nar_cls = CLS_UNK;
    endcase
  end

  always_comb begin
    wid_cls = CLS_UNK;
    priority if ((h[12:11] != 2'b10) || !lo[15]) begin
      wid_cls = CLS_UNK;
    end else if (lo[14] && lo[12]) begin
      wid_cls = CLS_BL;
    end else if (lo[14] || lo[12]) begin
      wid_cls = CLS_UNK;
    end else if (h[9:5] == 5'b11100) begin
      wid_cls = CLS_MSR;
    end else if (h[9:4] == 6'b111011) begin
      unique case (lo[7:4])
        4'd4:    wid_cls = CLS_DSB;
        4'd5:    wid_cls = CLS_DMB;
        4'd6:    wid_cls = CLS_ISB;
        default: wid_cls = CLS_UNK;
      endcase
    end else if (lo[13] && (h[10:4] == 7'h7f)) begin
      wid_cls = CLS_UDF;
    end else if (h[9:5] == 5'b11111) begin
      wid_cls = CLS_MRS;
    end else begin
      wid_cls = CLS_UNK;
    end
  end

  assign cls = wide ? wid_cls : nar_cls;

  always_comb begin
    disp = '0;
    priority if (cls == CLS_B) begin
      disp = {{20{h[10]}}, h[10:0], 1'b0};
    end else if (cls == CLS_B_COND) begin
      disp = {{23{h[7]}}, h[7:0], 1'b0};
    end else begin
      disp = {{7{h[10]}}, h[10], ~(lo[13] ^ h[10]), ~(lo[11] ^ h[10]),
              h[9:0], lo[10:0], 1'b0};
    end
  end

  assign sum = item_i.pc_addr + disp + AddrW'(4);

  always_comb begin
    ones = '0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + CountW'(h[i]);
    end
  end

  assign push_pop = (cls == CLS_PUSH) || (cls == CLS_POP);
  assign is_list  = push_pop || (cls == CLS_STM) || (cls == CLS_LDM);

  always_comb begin
    result_o                   = '0;
    result_o.is_wide           = wide;
    result_o.op_class          = cls;
    result_o.has_reg_list      = is_list;
    result_o.list_has_pc_or_lr = push_pop & h[8];
    if (is_list) begin
      result_o.reg_count = ones + CountW'(push_pop & h[8]);
    end
    priority if (cls == CLS_B) begin
      result_o.target_valid = 1'b1;
      result_o.dest_addr    = sum;
      result_o.disp_kind    = DK_DISP11;
    end else if (cls == CLS_B_COND) begin
      result_o.target_valid = 1'b1;
      result_o.dest_addr    = sum;
      result_o.disp_kind    = DK_DISP8;
    end else if (cls == CLS_BL) begin
      result_o.target_valid = 1'b1;
      result_o.dest_addr    = sum;
      result_o.disp_kind    = DK_DISP24;
    end else if ((cls == CLS_BX) || (cls == CLS_BLX)) begin
      result_o.disp_kind  = DK_INDIRECT;
      result_o.branch_reg = h[6:3];
    end else if ((cls == CLS_POP) && h[8]) begin
      result_o.disp_kind = DK_INDIRECT;
    end else begin
      result_o.disp_kind = DK_NONE;
    end
  end

endmodule
